// ===== hdl/spa_pkg.sv =====
package spa_pkg;

    // piece kind codes carried in the opcode field
    localparam logic KIND_ROOK   = 1'b0;
    localparam logic KIND_BISHOP = 1'b1;

    localparam int unsigned NUM_KINDS = 2;
    localparam int unsigned NUM_RAYS  = 4;
    localparam int unsigned NUM_STEPS = 7;

    // one ray direction, each component in -1..1
    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] df;
    } t_dir;

    // one query as it travels from the input register to the ray scan
    typedef struct packed {
        logic        opcode;
        logic [5:0]  square;
        logic [63:0] occupancy;
    } t_query;

    // ray directions per piece kind: rook orthogonal, bishop diagonal
    localparam t_dir RAY_DIR [NUM_KINDS][NUM_RAYS] = '{
        '{'{2'sd1, 2'sd0}, '{-2'sd1, 2'sd0}, '{2'sd0, 2'sd1}, '{2'sd0, -2'sd1}},
        '{'{2'sd1, 2'sd1}, '{2'sd1, -2'sd1}, '{-2'sd1, 2'sd1}, '{-2'sd1, -2'sd1}}
    };

endpackage

// ===== hdl/spa_if.sv =====
// request channel: piece kind, origin square and occupancy board
interface spa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [5:0]  square;
    logic [63:0] occupancy;

    modport source (output valid, output opcode, output square, output occupancy,
                    input ready);
    modport sink   (input valid, input opcode, input square, input occupancy,
                    output ready);
endinterface

// result channel: attack board
interface spa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] attacks;

    modport source (output valid, output attacks, input ready);
    modport sink   (input valid, input attacks, output ready);
endinterface

// ===== hdl/spa_ray.sv =====
module spa_ray (
    input  logic [5:0]    i_square,
    input  logic [63:0]   i_occupancy,
    input  spa_pkg::t_dir i_dir,
    output logic [63:0]   o_ray
);

    logic [4:0]  rank_pos;
    logic [4:0]  file_pos;
    logic [5:0]  idx;
    logic        blocked;
    logic        on_board;
    logic [63:0] ray;

    // walk outward from the origin, stopping after the first occupied square
    always_comb begin
        ray      = '0;
        blocked  = 1'b0;
        idx      = '0;
        on_board = 1'b0;
        rank_pos = {2'b00, i_square[5:3]};
        file_pos = {2'b00, i_square[2:0]};
        for (int k = 0; k < spa_pkg::NUM_STEPS; k++) begin
            rank_pos = rank_pos + {{3{i_dir.dr[1]}}, i_dir.dr};
            file_pos = file_pos + {{3{i_dir.df[1]}}, i_dir.df};
            // positions stay in -7..14, so the top two bits flag off-board
            on_board = (rank_pos[4:3] == 2'b00) && (file_pos[4:3] == 2'b00);
            idx      = {rank_pos[2:0], file_pos[2:0]};
            if (on_board && !blocked) begin
                ray[idx] = 1'b1;
                blocked  = i_occupancy[idx];
            end
        end
    end

    assign o_ray = ray;

endmodule

// ===== hdl/spa_attack_gen.sv =====
module spa_attack_gen (
    input  spa_pkg::t_query i_query,
    output logic [63:0]     o_attacks
);

    logic [63:0] ray [spa_pkg::NUM_RAYS];

    // four ray scanners, directions chosen by piece kind
    for (genvar g = 0; g < spa_pkg::NUM_RAYS; g++) begin : g_ray
        spa_ray u_ray (
            .i_square    (i_query.square),
            .i_occupancy (i_query.occupancy),
            .i_dir       (spa_pkg::RAY_DIR[i_query.opcode][g]),
            .o_ray       (ray[g])
        );
    end

    // merge the rays into one board
    always_comb begin
        o_attacks = '0;
        for (int r = 0; r < spa_pkg::NUM_RAYS; r++) begin
            o_attacks = o_attacks | ray[r];
        end
    end

endmodule

// ===== hdl/sliding_piece_attacks_top.sv =====
// Sliding piece attack generator. Each request gives a piece kind (0 rook,
// 1 bishop), an origin square (rank * 8 + file) and a 64-bit occupancy board;
// the result is the board of attacked squares, with the first blocker on each
// ray included and the origin never set. One request is taken per cycle unless
// a stall on the result channel backs up both registers: an accepted request
// sits in the input register while the four-ray scan works on it, and the
// result register loads the scan result once the result stage can advance.
// The ready of the request channel follows the result channel's ready through
// both registers, so while a finished result waits one more request can still
// enter an empty input register.
module sliding_piece_attacks_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spa_req_if.sink          i_req,
    spa_rsp_if.source        o_rsp
);

    logic            r_in_valid;
    logic            n_in_valid;
    spa_pkg::t_query r_in_query;
    spa_pkg::t_query n_in_query;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [63:0]     r_out_attacks;
    logic [63:0]     n_out_attacks;
    logic [63:0]     attacks;
    logic            out_advance;
    logic            in_advance;

    // attack scan between the two registers
    spa_attack_gen u_gen (
        .i_query   (r_in_query),
        .o_attacks (attacks)
    );

    // pipeline flow control
    assign out_advance = !r_out_valid || o_rsp.ready;
    assign in_advance  = !r_in_valid || out_advance;
    assign i_req.ready = in_advance;

    always_comb begin
        n_in_valid    = r_in_valid;
        n_in_query    = r_in_query;
        n_out_valid   = r_out_valid;
        n_out_attacks = r_out_attacks;
        if (in_advance) begin
            n_in_valid       = i_req.valid;
            n_in_query.opcode    = i_req.opcode;
            n_in_query.square    = i_req.square;
            n_in_query.occupancy = i_req.occupancy;
        end
        if (out_advance) begin
            n_out_valid   = r_in_valid;
            n_out_attacks = attacks;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in_query    <= n_in_query;
        r_out_attacks <= n_out_attacks;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.attacks = r_out_attacks;

endmodule

// ===== hdl/spa_checker.sv =====
module spa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_rsp_attacks
);

    // a result waiting on the sink stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its board
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_attacks))
        else $error("result board changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // with no result pending the request side is always open
    a_req_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request stalled with empty result register");

    // every square attacks something, and never more than a rook on an empty board
    a_attack_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_attacks != 64'd0) && ($countones(i_rsp_attacks) <= 14))
        else $error("attack board size out of range");

endmodule

bind sliding_piece_attacks_top spa_checker u_spa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_attacks (o_rsp.attacks)
);

// ===== dv/sliding_piece_attacks_checker.sv =====
// watches both channels, predicts each attack board and compares in order
module sliding_piece_attacks_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_opcode,
    input  logic [5:0]  i_req_square,
    input  logic [63:0] i_req_occupancy,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [63:0] i_rsp_attacks,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [5:0]  square;
        logic [63:0] occupancy;
        logic [63:0] attacks;
    } t_due_board;

    t_due_board attack_boards_due[$];
    int         mismatch_count;
    int         outstanding_count;

    // walk the four rays of the piece, stopping after the first occupied square
    function automatic logic [63:0] slider_attack_board(input logic kind,
                                                         input logic [5:0] sq,
                                                         input logic [63:0] occ);
        int          rank0;
        int          file0;
        int          r;
        int          f;
        int          dr;
        int          df;
        bit          blocked;
        logic [63:0] board;
        board = '0;
        rank0 = int'(sq[5:3]);
        file0 = int'(sq[2:0]);
        for (int d = 0; d < 4; d++) begin
            if (kind == spa_pkg::KIND_ROOK) begin
                // north, south, east, west
                dr = (d == 0) ? 1 : (d == 1) ? -1 : 0;
                df = (d == 2) ? 1 : (d == 3) ? -1 : 0;
            end else begin
                // the four diagonals
                dr = (d < 2) ? 1 : -1;
                df = (d % 2 == 0) ? 1 : -1;
            end
            r = rank0 + dr;
            f = file0 + df;
            blocked = 1'b0;
            while (!blocked && r >= 0 && r < 8 && f >= 0 && f < 8) begin
                board[r * 8 + f] = 1'b1;
                if (occ[r * 8 + f])
                    blocked = 1'b1;
                r += dr;
                f += df;
            end
        end
        return board;
    endfunction

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding_count;

    initial begin
        mismatch_count    = 0;
        outstanding_count = 0;
    end

    // record each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_due_board due;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                due.kind      = i_req_opcode;
                due.square    = i_req_square;
                due.occupancy = i_req_occupancy;
                due.attacks   = slider_attack_board(i_req_opcode, i_req_square,
                                                    i_req_occupancy);
                attack_boards_due.push_back(due);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (attack_boards_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("[%0t] unexpected result attacks=%h", $realtime,
                                 i_rsp_attacks);
                    mismatch_count++;
                end else begin
                    due = attack_boards_due.pop_front();
                    if (i_rsp_attacks !== due.attacks) begin
                        if (mismatch_count < 10)
                            $display("[%0t] kind=%0d square=%0d occ=%h: attacks exp=%h act=%h",
                                     $realtime, due.kind, due.square, due.occupancy,
                                     due.attacks, i_rsp_attacks);
                        mismatch_count++;
                    end
                end
            end
            outstanding_count = attack_boards_due.size();
        end
    end

endmodule

// ===== dv/sliding_piece_attacks_top_tb.sv =====
module sliding_piece_attacks_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_QUERIES = 700;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKED,
        SINK_TOGGLE
    } t_sink_mode;

    logic       i_clk;
    logic       i_rst_n;
    int         mismatches;
    int         outstanding;
    int         burst_left;
    t_sink_mode sink_mode;
    int         sink_mode_left;

    spa_req_if req_if ();
    spa_rsp_if rsp_if ();

    sliding_piece_attacks_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    sliding_piece_attacks_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_opcode    (req_if.opcode),
        .i_req_square    (req_if.square),
        .i_req_occupancy (req_if.occupancy),
        .i_rsp_valid     (rsp_if.valid),
        .i_rsp_ready     (rsp_if.ready),
        .i_rsp_attacks   (rsp_if.attacks),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    // random occupancy of varying density
    function automatic logic [63:0] random_board();
        logic [63:0] board;
        int          pieces;
        case ($urandom_range(0, 3))
            0: board = {$urandom, $urandom};
            1: board = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: board = {$urandom, $urandom} | {$urandom, $urandom};
            default: begin
                board = '0;
                pieces = $urandom_range(0, 4);
                for (int i = 0; i < pieces; i++)
                    board[$urandom_range(0, 63)] = 1'b1;
            end
        endcase
        return board;
    endfunction

    // present one request, idling between bursts, and hold it until taken
    task automatic send_query(input logic kind, input logic [5:0] sq,
                              input logic [63:0] occ);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid     <= 1'b0;
                req_if.opcode    <= 1'($urandom);
                req_if.square    <= 6'($urandom);
                req_if.occupancy <= {$urandom, $urandom};
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_if.valid     <= 1'b1;
        req_if.opcode    <= kind;
        req_if.square    <= sq;
        req_if.occupancy <= occ;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // result side stalls on a randomly chosen mode that is picked anew when its run ends
    initial begin
        rsp_if.ready   <= 1'b0;
        sink_mode      = SINK_OPEN;
        sink_mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_mode_left == 0) begin
                sink_mode      = t_sink_mode'($urandom_range(0, 3));
                sink_mode_left = $urandom_range(10, 60);
            end
            sink_mode_left--;
            case (sink_mode)
                SINK_OPEN:   rsp_if.ready <= 1'b1;
                SINK_COIN:   rsp_if.ready <= 1'($urandom);
                SINK_CHOKED: rsp_if.ready <= ($urandom_range(0, 7) == 0);
                default:     rsp_if.ready <= ~rsp_if.ready;
            endcase
        end
    end

    // reset, directed queries, random queries, drain and verdict
    initial begin
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.opcode    <= spa_pkg::KIND_ROOK;
        req_if.square    <= '0;
        req_if.occupancy <= '0;
        burst_left       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty board from the corners and the center, both pieces
        send_query(spa_pkg::KIND_ROOK,   6'd0,  '0);
        send_query(spa_pkg::KIND_BISHOP, 6'd0,  '0);
        send_query(spa_pkg::KIND_ROOK,   6'd7,  '0);
        send_query(spa_pkg::KIND_BISHOP, 6'd7,  '0);
        send_query(spa_pkg::KIND_ROOK,   6'd56, '0);
        send_query(spa_pkg::KIND_BISHOP, 6'd56, '0);
        send_query(spa_pkg::KIND_ROOK,   6'd63, '0);
        send_query(spa_pkg::KIND_BISHOP, 6'd63, '0);
        send_query(spa_pkg::KIND_ROOK,   6'd27, '0);
        send_query(spa_pkg::KIND_BISHOP, 6'd27, '0);
        // full board: only the neighbors are attacked
        send_query(spa_pkg::KIND_ROOK,   6'd36, '1);
        send_query(spa_pkg::KIND_BISHOP, 6'd36, '1);
        send_query(spa_pkg::KIND_ROOK,   6'd0,  '1);
        send_query(spa_pkg::KIND_BISHOP, 6'd63, '1);
        // origin occupied alone does not block anything
        send_query(spa_pkg::KIND_ROOK,   6'd35, 64'd1 << 35);
        send_query(spa_pkg::KIND_BISHOP, 6'd35, 64'd1 << 35);
        // blockers on the far edge and just next to the origin
        send_query(spa_pkg::KIND_ROOK,   6'd0,  (64'd1 << 56) | (64'd1 << 7));
        send_query(spa_pkg::KIND_BISHOP, 6'd9,  (64'd1 << 54) | (64'd1 << 0));
        send_query(spa_pkg::KIND_ROOK,   6'd31,
                   (64'd1 << 30) | (64'd1 << 39) | (64'd1 << 23));
        send_query(spa_pkg::KIND_BISHOP, 6'd60, (64'd1 << 51) | (64'd1 << 53));
        // edge origins with sides of the board missing
        send_query(spa_pkg::KIND_ROOK,   6'd24, {$urandom, $urandom});
        send_query(spa_pkg::KIND_BISHOP, 6'd39, {$urandom, $urandom});

        for (int n = 0; n < RANDOM_QUERIES; n++)
            send_query(1'($urandom), 6'($urandom), random_board());

        req_if.valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
